### rtl/core/pbv_pkg.sv
// ----------------------------------------------------------------------------
// pbv_pkg
// Shared types and constants for the polygon bounding volume block: vertex
// store geometry, datapath widths, record kinds and sequencer states.
// ----------------------------------------------------------------------------
package pbv_pkg;

    // Vertex set size and coordinate width
    localparam int MAX_POINTS = 32;
    localparam int COORD_BITS = 16;

    // Derived widths
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int PT_W    = 2 * COORD_BITS;
    localparam int SUM_W   = COORD_BITS + IDX_W;
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int DIST_W  = 2 * DIFF_W;
    localparam int DCNT_W  = $clog2(SUM_W + 1);

    // Port widths of the item fields
    localparam int IN_W    = 16;
    localparam int VALX_W  = 17;
    localparam int VALY_W  = 16;

    // One stored vertex
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } point_t;

    // Result record kinds
    typedef enum logic [2:0] {
        KIND_POINT    = 3'd0,
        KIND_BOX_CTR  = 3'd1,
        KIND_BOX_HALF = 3'd2,
        KIND_CENTROID = 3'd3,
        KIND_CIRC_CTR = 3'd4,
        KIND_RADIUS   = 3'd5
    } kind_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_RD_I,
        ST_IW,
        ST_RD_J,
        ST_JW,
        ST_MX,
        ST_MY,
        ST_CMP,
        ST_SW1,
        ST_SW2,
        ST_E_RD,
        ST_E_W,
        ST_SQI,
        ST_SQRT,
        ST_DIVX,
        ST_DIVY
    } state_t;

    // Record output runs as its own state after the dividers
    typedef enum logic {
        OUT_IDLE,
        OUT_REC
    } rec_state_t;

endpackage

### rtl/core/pbv_ram.sv
// ----------------------------------------------------------------------------
// pbv_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module pbv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/polygon_bounding_volumes.sv
// ----------------------------------------------------------------------------
// polygon_bounding_volumes
// Loads a vertex set, reorders it nearest-neighbour first in a vertex RAM,
// then emits the points and box, centroid and farthest-pair circle records.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  vertex   | start in, busy out     | point_x, point_y, last_point
//  record   | result_strobe out      | record_kind, value_x, value_y, last_result
//
//  A vertex without the last mark is taken; busy stays low.
//  A last mark raises busy for the set: the n*(n-1) pair evaluations over
//  the single read port and one shared multiplier, row starts, swaps, point
//  emission, the square root, the two centroid divides and the records.
//  rst_n clears the control state; the vertex RAM needs no clearing.
//  Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module polygon_bounding_volumes (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [pbv_pkg::IN_W-1:0]   point_x,
    input  logic signed [pbv_pkg::IN_W-1:0]   point_y,
    input  logic                              last_point,
    output logic                              result_strobe,
    output logic [2:0]                        record_kind,
    output logic signed [pbv_pkg::VALX_W-1:0] value_x,
    output logic signed [pbv_pkg::VALY_W-1:0] value_y,
    output logic                              last_result
);

    localparam int CB  = pbv_pkg::COORD_BITS;
    localparam int CW  = pbv_pkg::CNT_W;
    localparam int IW  = pbv_pkg::IDX_W;
    localparam int SW  = pbv_pkg::SUM_W;
    localparam int DFW = pbv_pkg::DIFF_W;
    localparam int DW  = pbv_pkg::DIST_W;
    localparam int VXW = pbv_pkg::VALX_W;
    localparam int VYW = pbv_pkg::VALY_W;
    localparam int DCNT_W_L = pbv_pkg::DCNT_W;

    // Sequencer and counters
    pbv_pkg::state_t     state_reg, state_next;
    pbv_pkg::rec_state_t rst_reg, rst_next;
    pbv_pkg::kind_t      rec_reg, rec_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       j_reg, j_next;
    logic                far_reg, far_next;

    // Load-time statistics
    logic signed [CB-1:0] min_x_reg, min_x_next, max_x_reg, max_x_next;
    logic signed [CB-1:0] min_y_reg, min_y_next, max_y_reg, max_y_next;
    logic signed [SW-1:0] sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;

    // Pair evaluation datapath
    pbv_pkg::point_t       pi_reg, pi_next, pj_reg, pj_next;
    logic signed [DFW-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [DW-1:0]         sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [DW-1:0]         bd_reg, bd_next;
    logic [CW-1:0]         best_reg, best_next;
    pbv_pkg::point_t       bp_reg, bp_next, first_reg, first_next;
    pbv_pkg::point_t       ca_reg, ca_next, cb_reg, cb_next;

    // Square root and divider
    logic [DW-1:0]        sq_v_reg, sq_v_next, sq_r_reg, sq_r_next;
    logic [DW-1:0]        sq_bit_reg, sq_bit_next;
    logic [SW-1:0]        div_a_reg, div_a_next;
    logic [CW-1:0]        div_rem_reg, div_rem_next;
    logic                 div_neg_reg, div_neg_next;
    logic [DCNT_W_L-1:0]  div_cnt_reg, div_cnt_next;
    logic signed [CB-1:0] cen_x_reg, cen_x_next, cen_y_reg, cen_y_next;

    // Output registers
    logic                  strobe_reg, strobe_next;
    logic [2:0]            kind_reg, kind_next;
    logic signed [VXW-1:0] vx_reg, vx_next;
    logic signed [VYW-1:0] vy_reg, vy_next;
    logic                  last_reg, last_next;

    // RAM port
    logic            ram_we;
    logic [IW-1:0]   ram_waddr, ram_raddr;
    pbv_pkg::point_t ram_wdata, rd_pt;
    logic [pbv_pkg::PT_W-1:0] ram_rdata;

    // Combinational helpers
    logic                  accept;
    logic signed [CB-1:0]  in_x, in_y;
    logic signed [DFW-1:0] mul_op;
    logic signed [DW-1:0]  prod;
    logic [DW-1:0]         pair_dist;
    logic                  first_pair;
    logic [CW:0]           rem_s;
    logic                  qbit;
    logic [DW-1:0]         sq_try;
    logic signed [VXW-1:0] hx_sum, hx_dif, cx_sum;
    logic signed [VXW-1:0] hy_sum, hy_dif, cy_sum;

    pbv_ram #(
        .WIDTH (pbv_pkg::PT_W),
        .DEPTH (pbv_pkg::MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_pt  = pbv_pkg::point_t'(ram_rdata);
    assign accept = start && !busy;
    assign in_x   = $signed(point_x[CB-1:0]);
    assign in_y   = $signed(point_y[CB-1:0]);

    // Share one squarer between the two axis differences
    assign mul_op     = (state_reg == pbv_pkg::ST_MX) ? dx_reg : dy_reg;
    assign prod       = mul_op * mul_op;
    assign pair_dist  = sqx_reg + sqy_reg;
    assign first_pair = (j_reg == (i_reg + CW'(1)));

    // Divider and square root step terms
    assign rem_s  = {div_rem_reg, div_a_reg[SW-1]};
    assign qbit   = (rem_s >= {1'b0, cnt_reg});
    assign sq_try = sq_r_reg + sq_bit_reg;

    // Record arithmetic on widened sums
    assign hx_sum = VXW'(max_x_reg) + VXW'(min_x_reg);
    assign hx_dif = VXW'(max_x_reg) - VXW'(min_x_reg);
    assign hy_sum = VXW'(max_y_reg) + VXW'(min_y_reg);
    assign hy_dif = VXW'(max_y_reg) - VXW'(min_y_reg);
    assign cx_sum = VXW'(ca_reg.x) + VXW'(cb_reg.x);
    assign cy_sum = VXW'(ca_reg.y) + VXW'(cb_reg.y);

    assign busy          = (state_reg != pbv_pkg::ST_LOAD) || (rst_reg != pbv_pkg::OUT_IDLE);
    assign result_strobe = strobe_reg;
    assign record_kind   = kind_reg;
    assign value_x       = vx_reg;
    assign value_y       = vy_reg;
    assign last_result   = last_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pbv_pkg::ST_LOAD;
            rst_reg    <= pbv_pkg::OUT_IDLE;
            rec_reg    <= pbv_pkg::KIND_BOX_CTR;
            cnt_reg    <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            far_reg    <= 1'b0;
            min_x_reg  <= '0;
            max_x_reg  <= '0;
            min_y_reg  <= '0;
            max_y_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            bd_reg     <= '0;
            best_reg   <= '0;
            div_cnt_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rst_reg    <= rst_next;
            rec_reg    <= rec_next;
            cnt_reg    <= cnt_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            far_reg    <= far_next;
            min_x_reg  <= min_x_next;
            max_x_reg  <= max_x_next;
            min_y_reg  <= min_y_next;
            max_y_reg  <= max_y_next;
            sum_x_reg  <= sum_x_next;
            sum_y_reg  <= sum_y_next;
            bd_reg     <= bd_next;
            best_reg   <= best_next;
            div_cnt_reg <= div_cnt_next;
            strobe_reg <= strobe_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pi_reg      <= pi_next;
        pj_reg      <= pj_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        sqx_reg     <= sqx_next;
        sqy_reg     <= sqy_next;
        bp_reg      <= bp_next;
        first_reg   <= first_next;
        ca_reg      <= ca_next;
        cb_reg      <= cb_next;
        sq_v_reg    <= sq_v_next;
        sq_r_reg    <= sq_r_next;
        sq_bit_reg  <= sq_bit_next;
        div_a_reg   <= div_a_next;
        div_rem_reg <= div_rem_next;
        div_neg_reg <= div_neg_next;
        cen_x_reg   <= cen_x_next;
        cen_y_reg   <= cen_y_next;
        kind_reg    <= kind_next;
        vx_reg      <= vx_next;
        vy_reg      <= vy_next;
        last_reg    <= last_next;
    end

    // Next state and datapath
    always_comb
    begin
        state_next   = state_reg;
        rst_next     = rst_reg;
        rec_next     = rec_reg;
        cnt_next     = cnt_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        far_next     = far_reg;
        min_x_next   = min_x_reg;
        max_x_next   = max_x_reg;
        min_y_next   = min_y_reg;
        max_y_next   = max_y_reg;
        sum_x_next   = sum_x_reg;
        sum_y_next   = sum_y_reg;
        pi_next      = pi_reg;
        pj_next      = pj_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        sqx_next     = sqx_reg;
        sqy_next     = sqy_reg;
        bd_next      = bd_reg;
        best_next    = best_reg;
        bp_next      = bp_reg;
        first_next   = first_reg;
        ca_next      = ca_reg;
        cb_next      = cb_reg;
        sq_v_next    = sq_v_reg;
        sq_r_next    = sq_r_reg;
        sq_bit_next  = sq_bit_reg;
        div_a_next   = div_a_reg;
        div_rem_next = div_rem_reg;
        div_neg_next = div_neg_reg;
        div_cnt_next = div_cnt_reg;
        cen_x_next   = cen_x_reg;
        cen_y_next   = cen_y_reg;
        strobe_next  = 1'b0;
        kind_next    = kind_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        last_next    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = cnt_reg[IW-1:0];
        ram_wdata    = '{x: in_x, y: in_y};
        ram_raddr    = i_reg[IW-1:0];

        unique case (state_reg)
            pbv_pkg::ST_LOAD:
            begin
                // Store the vertex and fold it into box and sums
                if (accept && (rst_reg == pbv_pkg::OUT_IDLE))
                begin
                    if (cnt_reg < CW'(pbv_pkg::MAX_POINTS))
                    begin
                        ram_we     = 1'b1;
                        sum_x_next = sum_x_reg + SW'(in_x);
                        sum_y_next = sum_y_reg + SW'(in_y);
                        cnt_next   = cnt_reg + CW'(1);
                        if (cnt_reg == '0)
                        begin
                            min_x_next = in_x;
                            max_x_next = in_x;
                            min_y_next = in_y;
                            max_y_next = in_y;
                        end
                        else
                        begin
                            if (in_x < min_x_reg) min_x_next = in_x;
                            if (in_x > max_x_reg) max_x_next = in_x;
                            if (in_y < min_y_reg) min_y_next = in_y;
                            if (in_y > max_y_reg) max_y_next = in_y;
                        end
                    end
                    if (last_point)
                    begin
                        i_next   = '0;
                        far_next = 1'b0;
                        if (cnt_next >= CW'(2))
                            state_next = pbv_pkg::ST_RD_I;
                        else
                            state_next = pbv_pkg::ST_E_RD;
                    end
                end
            end

            pbv_pkg::ST_RD_I:
            begin
                state_next = pbv_pkg::ST_IW;
            end

            pbv_pkg::ST_IW:
            begin
                pi_next    = rd_pt;
                j_next     = i_reg + CW'(1);
                state_next = pbv_pkg::ST_RD_J;
            end

            pbv_pkg::ST_RD_J:
            begin
                ram_raddr  = j_reg[IW-1:0];
                state_next = pbv_pkg::ST_JW;
            end

            pbv_pkg::ST_JW:
            begin
                pj_next    = rd_pt;
                dx_next    = DFW'(pi_reg.x) - DFW'(rd_pt.x);
                dy_next    = DFW'(pi_reg.y) - DFW'(rd_pt.y);
                state_next = pbv_pkg::ST_MX;
            end

            pbv_pkg::ST_MX:
            begin
                sqx_next   = $unsigned(prod);
                state_next = pbv_pkg::ST_MY;
            end

            pbv_pkg::ST_MY:
            begin
                sqy_next   = $unsigned(prod);
                state_next = pbv_pkg::ST_CMP;
            end

            pbv_pkg::ST_CMP:
            begin
                if (!far_reg)
                begin
                    // Nearest later point, first minimum wins
                    if (first_pair || (pair_dist < bd_reg))
                    begin
                        bd_next   = pair_dist;
                        best_next = j_reg;
                        bp_next   = pj_reg;
                    end
                    if (first_pair)
                        first_next = pj_reg;
                    if ((j_reg + CW'(1)) < cnt_reg)
                    begin
                        j_next     = j_reg + CW'(1);
                        state_next = pbv_pkg::ST_RD_J;
                    end
                    else
                        state_next = pbv_pkg::ST_SW1;
                end
                else
                begin
                    // Farthest pair, first strictly greatest wins
                    if (pair_dist > bd_reg)
                    begin
                        bd_next = pair_dist;
                        ca_next = pi_reg;
                        cb_next = pj_reg;
                    end
                    if ((j_reg + CW'(1)) < cnt_reg)
                    begin
                        j_next     = j_reg + CW'(1);
                        state_next = pbv_pkg::ST_RD_J;
                    end
                    else if ((i_reg + CW'(2)) < cnt_reg)
                    begin
                        i_next     = i_reg + CW'(1);
                        state_next = pbv_pkg::ST_RD_I;
                    end
                    else
                        state_next = pbv_pkg::ST_SQI;
                end
            end

            pbv_pkg::ST_SW1:
            begin
                // Move the nearest point into the next slot
                ram_we     = 1'b1;
                ram_waddr  = IW'(i_reg + CW'(1));
                ram_wdata  = bp_reg;
                state_next = pbv_pkg::ST_SW2;
            end

            pbv_pkg::ST_SW2:
            begin
                // Put the displaced point where the nearest one was
                ram_we    = 1'b1;
                ram_waddr = best_reg[IW-1:0];
                ram_wdata = first_reg;
                pi_next   = bp_reg;
                if ((i_reg + CW'(2)) < cnt_reg)
                begin
                    i_next     = i_reg + CW'(1);
                    j_next     = i_reg + CW'(2);
                    state_next = pbv_pkg::ST_RD_J;
                end
                else
                begin
                    i_next     = '0;
                    state_next = pbv_pkg::ST_E_RD;
                end
            end

            pbv_pkg::ST_E_RD:
            begin
                state_next = pbv_pkg::ST_E_W;
            end

            pbv_pkg::ST_E_W:
            begin
                // Emit one reordered point
                strobe_next = 1'b1;
                kind_next   = pbv_pkg::KIND_POINT;
                vx_next     = VXW'(rd_pt.x);
                vy_next     = VYW'(rd_pt.y);
                if ((i_reg + CW'(1)) < cnt_reg)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = pbv_pkg::ST_E_RD;
                end
                else
                begin
                    i_next   = '0;
                    far_next = 1'b1;
                    bd_next  = '0;
                    ca_next  = '0;
                    cb_next  = '0;
                    if (cnt_reg >= CW'(2))
                        state_next = pbv_pkg::ST_RD_I;
                    else
                        state_next = pbv_pkg::ST_SQI;
                end
            end

            pbv_pkg::ST_SQI:
            begin
                sq_v_next   = bd_reg;
                sq_r_next   = '0;
                sq_bit_next = DW'(1) << (DW - 2);
                state_next  = pbv_pkg::ST_SQRT;
            end

            pbv_pkg::ST_SQRT:
            begin
                // One root bit per cycle
                if (sq_bit_reg == '0)
                begin
                    div_a_next   = sum_x_reg[SW-1] ? SW'(-sum_x_reg) : sum_x_reg;
                    div_neg_next = sum_x_reg[SW-1];
                    div_rem_next = '0;
                    div_cnt_next = '0;
                    state_next   = pbv_pkg::ST_DIVX;
                end
                else
                begin
                    if (sq_v_reg >= sq_try)
                    begin
                        sq_v_next = sq_v_reg - sq_try;
                        sq_r_next = (sq_r_reg >> 1) + sq_bit_reg;
                    end
                    else
                        sq_r_next = sq_r_reg >> 1;
                    sq_bit_next = sq_bit_reg >> 2;
                end
            end

            pbv_pkg::ST_DIVX,
            pbv_pkg::ST_DIVY:
            begin
                // Restoring divide of the sum magnitude by the count
                if (div_cnt_reg == DCNT_W_L'(SW))
                begin
                    if (state_reg == pbv_pkg::ST_DIVX)
                    begin
                        cen_x_next   = CB'(div_neg_reg ? SW'(-div_a_reg) : div_a_reg);
                        div_a_next   = sum_y_reg[SW-1] ? SW'(-sum_y_reg) : sum_y_reg;
                        div_neg_next = sum_y_reg[SW-1];
                        div_rem_next = '0;
                        div_cnt_next = '0;
                        state_next   = pbv_pkg::ST_DIVY;
                    end
                    else
                    begin
                        cen_y_next = CB'(div_neg_reg ? SW'(-div_a_reg) : div_a_reg);
                        rec_next   = pbv_pkg::KIND_BOX_CTR;
                        rst_next   = pbv_pkg::OUT_REC;
                        state_next = pbv_pkg::ST_LOAD;
                    end
                end
                else
                begin
                    div_rem_next = qbit ? CW'(rem_s - {1'b0, cnt_reg}) : CW'(rem_s);
                    div_a_next   = {div_a_reg[SW-2:0], qbit};
                    div_cnt_next = div_cnt_reg + DCNT_W_L'(1);
                end
            end

            default:
            begin
                state_next = pbv_pkg::ST_LOAD;
            end
        endcase

        // Summary records, one per cycle, then drop the set
        if (rst_reg == pbv_pkg::OUT_REC)
        begin
            strobe_next = 1'b1;
            kind_next   = rec_reg;
            rec_next    = pbv_pkg::kind_t'(rec_reg + 3'd1);
            unique case (rec_reg)
                pbv_pkg::KIND_BOX_CTR:
                begin
                    vx_next = hx_sum >>> 1;
                    vy_next = VYW'(hy_sum >>> 1);
                end
                pbv_pkg::KIND_BOX_HALF:
                begin
                    vx_next = hx_dif >>> 1;
                    vy_next = VYW'(hy_dif >>> 1);
                end
                pbv_pkg::KIND_CENTROID:
                begin
                    vx_next = VXW'(cen_x_reg);
                    vy_next = VYW'(cen_y_reg);
                end
                pbv_pkg::KIND_CIRC_CTR:
                begin
                    vx_next = cx_sum >>> 1;
                    vy_next = VYW'(cy_sum >>> 1);
                end
                default:
                begin
                    vx_next    = $signed(VXW'(sq_r_reg >> 1));
                    vy_next    = '0;
                    last_next  = 1'b1;
                    rst_next   = pbv_pkg::OUT_IDLE;
                    cnt_next   = '0;
                    sum_x_next = '0;
                    sum_y_next = '0;
                    min_x_next = '0;
                    max_x_next = '0;
                    min_y_next = '0;
                    max_y_next = '0;
                end
            endcase
        end
    end

    // The run ends on the radius record only
    a_last_is_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last_result) |-> (record_kind == pbv_pkg::KIND_RADIUS))
        else $error("last result on a non-radius record");

    // The set never grows past the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(pbv_pkg::MAX_POINTS))
        else $error("vertex count past store depth");

    // While loading, the store is written only for an accepted vertex
    a_load_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pbv_pkg::ST_LOAD && ram_we) |-> accept)
        else $error("store write without an accepted item");

    // No result leaves while the block sits idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !$past(busy)) |-> !result_strobe)
        else $error("result strobe while idle");

endmodule
